FILE: hw/rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
// No dependencies; imported by skt_cell and sorted_key_table_core.
package skt_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_FIND   = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_DUP      = 2'd1;
    localparam logic [1:0] STS_NOTFOUND = 2'd2;
    localparam logic [1:0] STS_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [5:0]         rank;
        logic [7:0]         age_in;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] key_out;
        logic [7:0]         age_out;
        logic [6:0]         count_out;
    } t_rsp;

    // broadcast from the control to every cell
    typedef struct packed {
        logic               cmp;     // compare phase: latch flags
        logic               upd;     // update phase: shift or load
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [7:0]         age;
        logic               do_ins;
        logic               do_rem;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/skt_cell.sv
// One slot of the sorted table: a record plus its compare flags.
// Depends on skt_pkg; instantiated in a row by sorted_key_table_core.
module skt_cell (
    input  logic               i_clk,
    input  skt_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  logic               i_rank_hit,
    input  logic               i_lt_prev,
    input  logic signed [31:0] i_prev_key,
    input  logic [7:0]         i_prev_age,
    input  logic signed [31:0] i_next_key,
    input  logic [7:0]         i_next_age,
    output logic               o_lt,
    output logic signed [31:0] o_key,
    output logic [7:0]         o_age,
    output logic               o_hit,
    output logic signed [31:0] o_hit_key,
    output logic [7:0]         o_hit_age
);
    import skt_pkg::*;

    logic signed [31:0] r_key, n_key;
    logic [7:0]         r_age, n_age;
    logic               r_lt, r_hit;

    // read selects by rank, every other command by key match
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt  <= i_occ && (r_key < i_ctl.key);
            r_hit <= i_occ && ((i_ctl.cmd == CMD_READ) ? i_rank_hit
                                                       : (r_key == i_ctl.key));
        end
        r_key <= n_key;
        r_age <= n_age;
    end

    // lt flags form a prefix, so !i_lt_prev means this slot lies past the insert point
    always_comb begin
        n_key = r_key;
        n_age = r_age;
        if (i_ctl.upd && i_ctl.do_ins) begin
            if (!i_lt_prev) begin
                n_key = i_prev_key;
                n_age = i_prev_age;
            end else if (!r_lt) begin
                n_key = i_ctl.key;
                n_age = i_ctl.age;
            end
        end else if (i_ctl.upd && i_ctl.do_rem && !r_lt) begin
            n_key = i_next_key;
            n_age = i_next_age;
        end
    end

    assign o_lt      = r_lt;
    assign o_key     = r_key;
    assign o_age     = r_age;
    assign o_hit     = r_hit;
    assign o_hit_key = o_hit ? r_key : 32'sd0;
    assign o_hit_age = o_hit ? r_age : 8'd0;

endmodule

FILE: hw/rtl/sorted_key_table_core.sv
// Sorted key table: a row of skt_cell slots held in ascending key order.
// Depends on skt_pkg and skt_cell.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------
//  command  | start, busy          | i_req   (skt_pkg::t_req)
//  result   | o_valid (1-cycle)    | o_rsp   (skt_pkg::t_rsp)
//
// A command runs a compare phase, where every slot compares its key, then an update
// phase: the result register loads, a successful insert or remove shifts the row a slot.
// busy is high only in the compare phase, so a new command can be taken in the update.
// o_valid pulses for one cycle, the cycle after the update; it cannot be stalled.
// Reset clears the record count and the control; slot contents need no clearing.
module sorted_key_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  skt_pkg::t_req  i_req,
    output logic           o_valid,
    output skt_pkg::t_rsp  o_rsp
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_req             r_req;
    logic             r_valid;
    t_rsp             r_rsp, n_rsp;
    logic             accept;
    t_cell_ctl        ctl;

    logic               c_lt      [CAPACITY];
    logic signed [31:0] c_key     [CAPACITY];
    logic [7:0]         c_age     [CAPACITY];
    logic               c_hit     [CAPACITY];
    logic signed [31:0] c_hit_key [CAPACITY];
    logic [7:0]         c_hit_age [CAPACITY];

    logic               any_hit;
    logic signed [31:0] hit_key;
    logic [7:0]         hit_age;
    logic               full;
    logic [CNT_W+6:0]   cnt_ext;
    logic [CNT_W+5:0]   rank_ext;

    assign busy   = (r_state == S_CMP);
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign rank_ext = {{CNT_W{1'b0}}, r_req.rank};

    always_comb begin
        ctl.cmp    = (r_state == S_CMP);
        ctl.upd    = (r_state == S_UPD);
        ctl.cmd    = r_req.cmd;
        ctl.key    = r_req.key;
        ctl.age    = r_req.age_in;
        ctl.do_ins = (r_req.cmd == CMD_INSERT) && !any_hit && !full;
        ctl.do_rem = (r_req.cmd == CMD_REMOVE) && any_hit;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic               lt_prev;
        logic signed [31:0] prev_key, next_key;
        logic [7:0]         prev_age, next_age;

        if (g == 0) begin : g_first
            assign lt_prev  = 1'b1;
            assign prev_key = 32'sd0;
            assign prev_age = 8'd0;
        end else begin : g_mid
            assign lt_prev  = c_lt[g-1];
            assign prev_key = c_key[g-1];
            assign prev_age = c_age[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_key = 32'sd0;
            assign next_age = 8'd0;
        end else begin : g_inner
            assign next_key = c_key[g+1];
            assign next_age = c_age[g+1];
        end

        skt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occ      (CNT_W'(g) < r_count),
            .i_rank_hit (rank_ext == (CNT_W + 6)'(g)),
            .i_lt_prev  (lt_prev),
            .i_prev_key (prev_key),
            .i_prev_age (prev_age),
            .i_next_key (next_key),
            .i_next_age (next_age),
            .o_lt       (c_lt[g]),
            .o_key      (c_key[g]),
            .o_age      (c_age[g]),
            .o_hit      (c_hit[g]),
            .o_hit_key  (c_hit_key[g]),
            .o_hit_age  (c_hit_age[g])
        );
    end

    // at most one slot hits, so an OR collects its record
    always_comb begin
        any_hit = 1'b0;
        hit_key = 32'sd0;
        hit_age = 8'd0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_hit = any_hit | c_hit[i];
            hit_key = hit_key | c_hit_key[i];
            hit_age = hit_age | c_hit_age[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (ctl.upd && ctl.do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.upd && ctl.do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
        cnt_ext = {7'd0, n_count};

        n_rsp.count_out = cnt_ext[6:0];
        n_rsp.key_out   = hit_key;
        n_rsp.age_out   = hit_age;
        n_rsp.status    = any_hit ? STS_OK : STS_NOTFOUND;
        if (r_req.cmd == CMD_INSERT) begin
            n_rsp.key_out = 32'sd0;
            n_rsp.age_out = 8'd0;
            if (any_hit) begin
                n_rsp.status = STS_DUP;
            end else if (full) begin
                n_rsp.status = STS_FULL;
            end else begin
                n_rsp.status = STS_OK;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= ctl.upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (ctl.upd) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_cmp_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (r_state == S_UPD))
        else $error("compare phase did not end after one cycle");

    a_valid_follows_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> o_valid)
        else $error("update not followed by a result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("record count above capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.upd && ctl.do_ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not bump the count");

endmodule
